>>> src/cpd_pkg.sv
// Shared types, constants and helper function of the printer command decoder.
package cpd_pkg;

	// Tab-stop list capacity and the width of its fill count.
	localparam int MAX_TAB_STOPS = 32;
	localparam int TAB_CNT_W = $clog2(MAX_TAB_STOPS + 1);

	// Configuration register indexes.
	localparam logic CFG_FINE_UNITS = 1'b0;
	localparam logic CFG_COLON_PITCH = 1'b1;

	// Control bytes of the text phase.
	localparam logic [7:0] CC_ESC = 8'h1B;
	localparam logic [7:0] CC_CR = 8'h0D;
	localparam logic [7:0] CC_LF = 8'h0A;
	localparam logic [7:0] CC_FF = 8'h0C;
	localparam logic [7:0] CC_BS = 8'h08;
	localparam logic [7:0] CC_HT = 8'h09;
	localparam logic [7:0] CC_CAN = 8'h18;
	localparam logic [7:0] CC_SO = 8'h0E;
	localparam logic [7:0] CC_DC4 = 8'h14;
	localparam logic [7:0] CC_SI = 8'h0F;
	localparam logic [7:0] CC_DC2 = 8'h12;
	localparam logic [7:0] CC_SPACE = 8'h20;

	// Escape command bytes.
	localparam logic [7:0] EC_RESET = 8'h40; // @
	localparam logic [7:0] EC_BOLD_ON = 8'h45; // E
	localparam logic [7:0] EC_BOLD_OFF = 8'h46; // F
	localparam logic [7:0] EC_DSTRIKE_ON = 8'h47; // G
	localparam logic [7:0] EC_DSTRIKE_OFF = 8'h48; // H
	localparam logic [7:0] EC_UPPER_ON = 8'h36; // 6
	localparam logic [7:0] EC_UPPER_OFF = 8'h37; // 7
	localparam logic [7:0] EC_MSB_CLEAR = 8'h23; // #
	localparam logic [7:0] EC_MSB_ZERO = 8'h3D; // =
	localparam logic [7:0] EC_MSB_ONE = 8'h3E; // >
	localparam logic [7:0] EC_SCRIPT_OFF = 8'h54; // T
	localparam logic [7:0] EC_PICA = 8'h50; // P
	localparam logic [7:0] EC_ELITE = 8'h4D; // M
	localparam logic [7:0] EC_MICRON = 8'h67; // g
	localparam logic [7:0] EC_LS_EIGHTH = 8'h30; // 0
	localparam logic [7:0] EC_LS_SIXTH = 8'h32; // 2
	localparam logic [7:0] EC_LS_SEVEN = 8'h31; // 1
	localparam logic [7:0] EC_PERF_OFF = 8'h4F; // O
	localparam logic [7:0] EC_UNI_ONE_LINE = 8'h3C; // <
	localparam logic [7:0] EC_UNDERLINE = 8'h2D; // -
	localparam logic [7:0] EC_SCRIPT = 8'h53; // S
	localparam logic [7:0] EC_EXPAND = 8'h57; // W
	localparam logic [7:0] EC_UNIDIR = 8'h55; // U
	localparam logic [7:0] EC_LS_N72 = 8'h41; // A
	localparam logic [7:0] EC_LS_N216 = 8'h33; // 3
	localparam logic [7:0] EC_FEED_N = 8'h4A; // J
	localparam logic [7:0] EC_LEFT_MARGIN = 8'h6C; // l
	localparam logic [7:0] EC_RIGHT_MARGIN = 8'h51; // Q
	localparam logic [7:0] EC_PERF_SKIP = 8'h4E; // N
	localparam logic [7:0] EC_PROP = 8'h70; // p
	localparam logic [7:0] EC_PAGE_LEN = 8'h43; // C
	localparam logic [7:0] EC_CHARSET = 8'h52; // R
	localparam logic [7:0] EC_MASTER = 8'h21; // !
	localparam logic [7:0] EC_TABS = 8'h44; // D
	localparam logic [7:0] EC_GFX_K = 8'h4B; // K
	localparam logic [7:0] EC_GFX_L = 8'h4C; // L
	localparam logic [7:0] EC_GFX_Y = 8'h59; // Y
	localparam logic [7:0] EC_GFX_Z = 8'h5A; // Z
	localparam logic [7:0] EC_GFX_MODE = 8'h2A; // *
	localparam logic [7:0] EC_GFX_NINE = 8'h5E; // ^
	localparam logic [7:0] EC_COLON = 8'h3A; // :

	// Script select parameters.
	localparam logic [7:0] SCR_SUPER_BIN = 8'd0;
	localparam logic [7:0] SCR_SUPER_ASC = 8'd48;
	localparam logic [7:0] SCR_SUB_BIN = 8'd1;
	localparam logic [7:0] SCR_SUB_ASC = 8'd49;

	// Fixed line spacings in 1/72 inch.
	localparam logic [7:0] LS_EIGHTH = 8'd9;
	localparam logic [7:0] LS_SIXTH = 8'd12;
	localparam logic [7:0] LS_SEVEN = 8'd7;

	// Spacing unit codes.
	localparam logic [1:0] UNIT_72 = 2'd0;

	// Pitch codes.
	localparam logic [1:0] PITCH_10 = 2'd0;
	localparam logic [1:0] PITCH_12 = 2'd1;
	localparam logic [1:0] PITCH_15 = 2'd2;

	// Dot width codes.
	localparam logic [2:0] DW_60 = 3'd0;
	localparam logic [2:0] DW_120 = 3'd1;
	localparam logic [2:0] DW_240 = 3'd2;

	// Attribute bit positions.
	localparam int ATB_BOLD = 0;
	localparam int ATB_UNDER = 1;
	localparam int ATB_COND = 2;
	localparam int ATB_EXP = 3;
	localparam int ATB_EXPLINE = 4;
	localparam int ATB_PROP = 5;
	localparam int ATB_SUPER = 6;
	localparam int ATB_SUB = 7;
	localparam int ATB_UNI = 8;

	// Parse phases.
	typedef enum logic [3:0] {
		PH_TEXT = 4'd0,
		PH_ESC = 4'd1,
		PH_PARAM = 4'd2,
		PH_MASTER = 4'd3,
		PH_INCHES = 4'd4,
		PH_CNT_LO = 4'd5,
		PH_CNT_HI = 4'd6,
		PH_DATA = 4'd7,
		PH_FIRST9 = 4'd8,
		PH_MODE = 4'd9,
		PH_MODE_LO = 4'd10,
		PH_TABS = 4'd11
	} phase_t;

	// Decoded event kinds.
	typedef enum logic [4:0] {
		EV_CHAR = 5'd0,
		EV_CR = 5'd1,
		EV_LF = 5'd2,
		EV_FF = 5'd3,
		EV_BS = 5'd4,
		EV_HT = 5'd5,
		EV_CAN = 5'd6,
		EV_GFX = 5'd7,
		EV_LINE_SPACING = 5'd8,
		EV_FEED = 5'd9,
		EV_LEFT_MARGIN = 5'd10,
		EV_RIGHT_MARGIN = 5'd11,
		EV_PAGE_LINES = 5'd12,
		EV_PAGE_INCHES = 5'd13,
		EV_TAB_SET = 5'd14,
		EV_PERF_SKIP = 5'd15,
		EV_RESET = 5'd16,
		EV_UNKNOWN = 5'd17
	} event_kind_t;

	// Configuration register contents.
	typedef struct packed {
		logic fine_units;
		logic colon_pitch;
	} cfg_t;

	// Parser state carried from byte to byte.
	typedef struct packed {
		phase_t phase;
		logic [7:0] pending;
		logic [7:0] cnt_lo;
		logic [16:0] bytes_left;
		logic nine_pin;
		logic [2:0] dot_width;
		logic [7:0] first_pin;
		logic [8:0] attr;
		logic [1:0] pitch;
		logic [7:0] charset;
		logic [TAB_CNT_W-1:0] tabs;
	} dec_state_t;

	// One decoded event.
	typedef struct packed {
		event_kind_t kind;
		logic [7:0] param;
		logic [1:0] unit;
		logic [8:0] pins;
		logic [2:0] dot_width;
		logic [1:0] pitch;
		logic [8:0] attr;
		logic [7:0] charset;
		logic [4:0] slot;
	} event_t;

	// Dot width code selected by a graphics mode byte; unknown modes use 1/60.
	function automatic logic [2:0] mode_width(input logic [7:0] mode);
		logic [2:0] w;
		unique case (mode)
			8'd0: w = 3'd0;
			8'd1: w = 3'd1;
			8'd2: w = 3'd1;
			8'd3: w = 3'd2;
			8'd4: w = 3'd3;
			8'd5: w = 3'd4;
			8'd6: w = 3'd5;
			default: w = DW_60;
		endcase
		return w;
	endfunction

endpackage

>>> src/cpd_byte_if.sv
// Input channel that carries one host byte per transaction.
interface cpd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

>>> src/cpd_event_if.sv
// Output channel that carries one decoded event per transaction.
interface cpd_event_if;
	logic valid;
	logic ready;
	logic [4:0] event_kind;
	logic [7:0] param_value;
	logic [1:0] spacing_unit;
	logic [8:0] pin_pattern;
	logic [2:0] dot_width_code;
	logic [1:0] pitch_code;
	logic [8:0] attribute_vector;
	logic [7:0] charset_code;
	logic [4:0] tab_slot;

	modport source (
		output valid, output event_kind, output param_value, output spacing_unit,
		output pin_pattern, output dot_width_code, output pitch_code,
		output attribute_vector, output charset_code, output tab_slot,
		input ready
	);
	modport sink (
		input valid, input event_kind, input param_value, input spacing_unit,
		input pin_pattern, input dot_width_code, input pitch_code,
		input attribute_vector, input charset_code, input tab_slot,
		output ready
	);
endinterface

>>> src/cpd_decode.sv
// Combinational decode of one byte against the current parser state.
module cpd_decode (
	input cpd_pkg::dec_state_t cur,
	input logic [7:0] data_byte,
	input cpd_pkg::cfg_t cfg,
	output cpd_pkg::dec_state_t nxt,
	output logic emit,
	output cpd_pkg::event_t ev
);

	// Next state and event for the byte in hand.
	always_comb begin
		logic [1:0] coarse;
		logic [1:0] finer;
		logic [16:0] count;
		coarse = {cfg.fine_units, 1'b0};
		finer = {cfg.fine_units, 1'b1};
		count = cur.nine_pin ? {data_byte, cur.cnt_lo, 1'b0} : {1'b0, data_byte, cur.cnt_lo};
		nxt = cur;
		emit = 1'b0;
		ev = '0;

		unique case (cur.phase)
			cpd_pkg::PH_ESC: begin
				nxt.phase = cpd_pkg::PH_TEXT;
				unique case (data_byte)
					cpd_pkg::EC_RESET: begin
						nxt.attr = '0;
						nxt.pitch = cpd_pkg::PITCH_10;
						nxt.charset = '0;
						nxt.tabs = '0;
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_RESET;
					end
					cpd_pkg::EC_BOLD_ON: nxt.attr[cpd_pkg::ATB_BOLD] = 1'b1;
					cpd_pkg::EC_BOLD_OFF: nxt.attr[cpd_pkg::ATB_BOLD] = 1'b0;
					cpd_pkg::EC_DSTRIKE_ON, cpd_pkg::EC_DSTRIKE_OFF, cpd_pkg::EC_UPPER_ON,
					cpd_pkg::EC_UPPER_OFF, cpd_pkg::EC_MSB_CLEAR, cpd_pkg::EC_MSB_ZERO,
					cpd_pkg::EC_MSB_ONE: begin
						emit = 1'b0;
					end
					cpd_pkg::EC_SCRIPT_OFF: begin
						nxt.attr[cpd_pkg::ATB_SUPER] = 1'b0;
						nxt.attr[cpd_pkg::ATB_SUB] = 1'b0;
					end
					cpd_pkg::EC_PICA: begin
						nxt.pitch = cpd_pkg::PITCH_10;
						nxt.attr[cpd_pkg::ATB_PROP] = 1'b0;
					end
					cpd_pkg::EC_ELITE: nxt.pitch = cpd_pkg::PITCH_12;
					cpd_pkg::EC_MICRON: nxt.pitch = cpd_pkg::PITCH_15;
					cpd_pkg::EC_LS_EIGHTH: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_LINE_SPACING;
						ev.param = cpd_pkg::LS_EIGHTH;
						ev.unit = cpd_pkg::UNIT_72;
					end
					cpd_pkg::EC_LS_SIXTH: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_LINE_SPACING;
						ev.param = cpd_pkg::LS_SIXTH;
						ev.unit = cpd_pkg::UNIT_72;
					end
					cpd_pkg::EC_LS_SEVEN: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_LINE_SPACING;
						ev.param = cpd_pkg::LS_SEVEN;
						ev.unit = cpd_pkg::UNIT_72;
					end
					cpd_pkg::EC_PERF_OFF: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_PERF_SKIP;
					end
					cpd_pkg::EC_UNI_ONE_LINE: nxt.attr[cpd_pkg::ATB_UNI] = 1'b1;
					cpd_pkg::EC_UNDERLINE, cpd_pkg::EC_SCRIPT, cpd_pkg::EC_EXPAND,
					cpd_pkg::EC_UNIDIR, cpd_pkg::EC_LS_N72, cpd_pkg::EC_LS_N216,
					cpd_pkg::EC_FEED_N, cpd_pkg::EC_LEFT_MARGIN, cpd_pkg::EC_RIGHT_MARGIN,
					cpd_pkg::EC_PERF_SKIP, cpd_pkg::EC_PROP, cpd_pkg::EC_PAGE_LEN,
					cpd_pkg::EC_CHARSET: begin
						nxt.pending = data_byte;
						nxt.phase = cpd_pkg::PH_PARAM;
					end
					cpd_pkg::EC_MASTER: nxt.phase = cpd_pkg::PH_MASTER;
					cpd_pkg::EC_TABS: begin
						nxt.tabs = '0;
						nxt.phase = cpd_pkg::PH_TABS;
					end
					cpd_pkg::EC_GFX_K, cpd_pkg::EC_GFX_L, cpd_pkg::EC_GFX_Y,
					cpd_pkg::EC_GFX_Z: begin
						if (data_byte == cpd_pkg::EC_GFX_K) begin
							nxt.dot_width = cpd_pkg::DW_60;
						end else if (data_byte == cpd_pkg::EC_GFX_Z) begin
							nxt.dot_width = cpd_pkg::DW_240;
						end else begin
							nxt.dot_width = cpd_pkg::DW_120;
						end
						nxt.nine_pin = 1'b0;
						nxt.pending = data_byte;
						nxt.phase = cpd_pkg::PH_CNT_LO;
					end
					cpd_pkg::EC_GFX_MODE: begin
						nxt.nine_pin = 1'b0;
						nxt.phase = cpd_pkg::PH_MODE;
					end
					cpd_pkg::EC_GFX_NINE: begin
						nxt.nine_pin = 1'b1;
						nxt.pending = data_byte;
						nxt.phase = cpd_pkg::PH_MODE;
					end
					cpd_pkg::EC_COLON: begin
						if (cfg.colon_pitch) begin
							nxt.pitch = cpd_pkg::PITCH_12;
						end else begin
							emit = 1'b1;
							ev.kind = cpd_pkg::EV_UNKNOWN;
							ev.param = data_byte;
						end
					end
					default: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_UNKNOWN;
						ev.param = data_byte;
					end
				endcase
			end

			// One-byte parameter of the pending escape command.
			cpd_pkg::PH_PARAM: begin
				nxt.phase = cpd_pkg::PH_TEXT;
				ev.param = data_byte;
				unique case (cur.pending)
					cpd_pkg::EC_UNDERLINE: nxt.attr[cpd_pkg::ATB_UNDER] = data_byte[0];
					cpd_pkg::EC_SCRIPT: begin
						nxt.attr[cpd_pkg::ATB_SUPER] = (data_byte == cpd_pkg::SCR_SUPER_BIN) ||
							(data_byte == cpd_pkg::SCR_SUPER_ASC);
						nxt.attr[cpd_pkg::ATB_SUB] = (data_byte == cpd_pkg::SCR_SUB_BIN) ||
							(data_byte == cpd_pkg::SCR_SUB_ASC);
					end
					cpd_pkg::EC_EXPAND: nxt.attr[cpd_pkg::ATB_EXP] = data_byte[0];
					cpd_pkg::EC_UNIDIR: nxt.attr[cpd_pkg::ATB_UNI] = data_byte[0];
					cpd_pkg::EC_PROP: nxt.attr[cpd_pkg::ATB_PROP] = data_byte[0];
					cpd_pkg::EC_LS_N72: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_LINE_SPACING;
						ev.unit = coarse;
					end
					cpd_pkg::EC_LS_N216: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_LINE_SPACING;
						ev.unit = finer;
					end
					cpd_pkg::EC_FEED_N: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_FEED;
						ev.unit = finer;
					end
					cpd_pkg::EC_LEFT_MARGIN: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_LEFT_MARGIN;
					end
					cpd_pkg::EC_RIGHT_MARGIN: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_RIGHT_MARGIN;
					end
					cpd_pkg::EC_PERF_SKIP: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_PERF_SKIP;
					end
					cpd_pkg::EC_PAGE_LEN: begin
						// A zero line count means the length follows in inches.
						if (data_byte == 8'd0) begin
							nxt.phase = cpd_pkg::PH_INCHES;
						end else begin
							emit = 1'b1;
							ev.kind = cpd_pkg::EV_PAGE_LINES;
						end
					end
					cpd_pkg::EC_CHARSET: nxt.charset = data_byte;
					default: emit = 1'b0;
				endcase
			end

			cpd_pkg::PH_INCHES: begin
				nxt.phase = cpd_pkg::PH_TEXT;
				if (data_byte != 8'd0) begin
					emit = 1'b1;
					ev.kind = cpd_pkg::EV_PAGE_INCHES;
					ev.param = data_byte;
				end
			end

			// Master select rewrites pitch and several attributes at once.
			cpd_pkg::PH_MASTER: begin
				nxt.phase = cpd_pkg::PH_TEXT;
				nxt.pitch = data_byte[0] ? cpd_pkg::PITCH_12 : cpd_pkg::PITCH_10;
				nxt.attr[cpd_pkg::ATB_PROP] = data_byte[1];
				nxt.attr[cpd_pkg::ATB_COND] = data_byte[2];
				nxt.attr[cpd_pkg::ATB_BOLD] = data_byte[3];
				nxt.attr[cpd_pkg::ATB_EXP] = data_byte[5];
				nxt.attr[cpd_pkg::ATB_UNDER] = data_byte[7];
			end

			cpd_pkg::PH_MODE: begin
				nxt.dot_width = cpd_pkg::mode_width(data_byte);
				nxt.phase = cpd_pkg::PH_MODE_LO;
			end

			cpd_pkg::PH_MODE_LO, cpd_pkg::PH_CNT_LO: begin
				nxt.cnt_lo = data_byte;
				nxt.phase = cpd_pkg::PH_CNT_HI;
			end

			// Column count complete: bytes expected, doubled for 9-pin runs.
			cpd_pkg::PH_CNT_HI: begin
				nxt.bytes_left = count;
				if (count == '0) begin
					nxt.phase = cpd_pkg::PH_TEXT;
				end else begin
					nxt.phase = cur.nine_pin ? cpd_pkg::PH_FIRST9 : cpd_pkg::PH_DATA;
				end
			end

			cpd_pkg::PH_FIRST9: begin
				nxt.first_pin = data_byte;
				nxt.phase = cpd_pkg::PH_DATA;
			end

			// Graphics data: one column per byte, or per byte pair in 9-pin runs.
			cpd_pkg::PH_DATA: begin
				emit = 1'b1;
				ev.kind = cpd_pkg::EV_GFX;
				ev.dot_width = cur.dot_width;
				if (cur.nine_pin) begin
					nxt.bytes_left = (cur.bytes_left > 17'd2) ? cur.bytes_left - 17'd2 : '0;
					nxt.phase = (cur.bytes_left > 17'd2) ? cpd_pkg::PH_FIRST9 : cpd_pkg::PH_TEXT;
					ev.pins = {data_byte[0], cur.first_pin};
				end else begin
					nxt.bytes_left = (cur.bytes_left > 17'd1) ? cur.bytes_left - 17'd1 : '0;
					if (cur.bytes_left <= 17'd1) begin
						nxt.phase = cpd_pkg::PH_TEXT;
					end
					ev.pins = {1'b0, data_byte};
				end
			end

			// Tab list: ends at a zero byte, extra stops are dropped.
			cpd_pkg::PH_TABS: begin
				if (data_byte == 8'd0) begin
					nxt.phase = cpd_pkg::PH_TEXT;
				end else if (cur.tabs < cpd_pkg::TAB_CNT_W'(cpd_pkg::MAX_TAB_STOPS)) begin
					nxt.tabs = cur.tabs + 1'b1;
					emit = 1'b1;
					ev.kind = cpd_pkg::EV_TAB_SET;
					ev.param = data_byte;
					ev.slot = 5'(cur.tabs);
				end
			end

			// Plain text, and any phase code that has no meaning.
			default: begin
				nxt.phase = cpd_pkg::PH_TEXT;
				unique case (data_byte)
					cpd_pkg::CC_ESC: nxt.phase = cpd_pkg::PH_ESC;
					cpd_pkg::CC_CR: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_CR;
					end
					cpd_pkg::CC_LF: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_LF;
					end
					cpd_pkg::CC_FF: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_FF;
					end
					cpd_pkg::CC_BS: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_BS;
					end
					cpd_pkg::CC_HT: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_HT;
					end
					cpd_pkg::CC_CAN: begin
						emit = 1'b1;
						ev.kind = cpd_pkg::EV_CAN;
					end
					cpd_pkg::CC_SO: nxt.attr[cpd_pkg::ATB_EXPLINE] = 1'b1;
					cpd_pkg::CC_DC4: nxt.attr[cpd_pkg::ATB_EXPLINE] = 1'b0;
					cpd_pkg::CC_SI: nxt.attr[cpd_pkg::ATB_COND] = 1'b1;
					cpd_pkg::CC_DC2: nxt.attr[cpd_pkg::ATB_COND] = 1'b0;
					default: begin
						if (data_byte >= cpd_pkg::CC_SPACE) begin
							emit = 1'b1;
							ev.kind = cpd_pkg::EV_CHAR;
							ev.param = data_byte;
						end
					end
				endcase
			end
		endcase

		// Every event carries the settings as they stand after this byte.
		ev.pitch = nxt.pitch;
		ev.attr = nxt.attr;
		ev.charset = nxt.charset;
	end

endmodule

>>> src/dot_matrix_printer_command_decoder.sv
// A byte goes from the input register through the decoder into the event register.
// Throughput: one byte per cycle; the input register, the parser state and the
// event register advance together, and a waiting event stalls only a byte that has one.
// Reset (arst_n low, asynchronous): text phase, attributes, pitch, character set,
// tab count and configuration cleared; both pipeline registers empty.
module dot_matrix_printer_command_decoder (
	input logic clk,
	input logic arst_n,
	cpd_byte_if.sink host,
	cpd_event_if.source events,
	input logic cfg_we,
	input logic cfg_index,
	input logic cfg_wdata
);

	logic [7:0] byte_s1;
	logic vld_s1;
	cpd_pkg::dec_state_t st_q;
	cpd_pkg::dec_state_t st_nxt;
	cpd_pkg::cfg_t cfg_q;
	cpd_pkg::event_t ev_q;
	cpd_pkg::event_t ev_nxt;
	logic out_vld_q;
	logic emit;
	logic adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpd_pkg::CFG_FINE_UNITS: cfg_q.fine_units <= cfg_wdata;
				cpd_pkg::CFG_COLON_PITCH: cfg_q.colon_pitch <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	cpd_decode u_decode (
		.cur(st_q),
		.data_byte(byte_s1),
		.cfg(cfg_q),
		.nxt(st_nxt),
		.emit(emit),
		.ev(ev_nxt)
	);

	// The held byte retires unless it has an event and the event register is blocked.
	assign adv = vld_s1 && (!emit || !out_vld_q || events.ready);
	assign host.ready = !vld_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (host.ready) begin
			vld_s1 <= host.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (host.valid && host.ready) begin
			byte_s1 <= host.data_byte;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: cpd_pkg::PH_TEXT, default: '0};
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// Event register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && emit) begin
			out_vld_q <= 1'b1;
		end else if (events.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			ev_q <= ev_nxt;
		end
	end

	assign events.valid = out_vld_q;
	assign events.event_kind = ev_q.kind;
	assign events.param_value = ev_q.param;
	assign events.spacing_unit = ev_q.unit;
	assign events.pin_pattern = ev_q.pins;
	assign events.dot_width_code = ev_q.dot_width;
	assign events.pitch_code = ev_q.pitch;
	assign events.attribute_vector = ev_q.attr;
	assign events.charset_code = ev_q.charset;
	assign events.tab_slot = ev_q.slot;

	// The tab count never passes the list capacity.
	a_tab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.tabs <= cpd_pkg::TAB_CNT_W'(cpd_pkg::MAX_TAB_STOPS))
		else $error("tab count beyond capacity");

	// A data phase always has bytes outstanding.
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == cpd_pkg::PH_DATA || st_q.phase == cpd_pkg::PH_FIRST9)
		|-> st_q.bytes_left != '0)
		else $error("graphics data phase with no bytes left");

	// The first byte of a pin pair is only awaited in a 9-pin run.
	a_first9_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == cpd_pkg::PH_FIRST9 |-> st_q.nine_pin)
		else $error("pin pair phase outside a 9-pin run");

	// Graphics columns come only from the data phase.
	a_gfx_source: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && ev_nxt.kind == cpd_pkg::EV_GFX |-> st_q.phase == cpd_pkg::PH_DATA)
		else $error("graphics column outside data phase");

	// A stalled byte stays in the input register unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(byte_s1))
		else $error("stalled byte lost");

endmodule
